### src/timer16_ctc_with_irq_select_assert.svh
// assertion helpers shared by the timer rtl
// each macro expects signals named clock and reset in the calling module
`ifndef TIMER16_CTC_WITH_IRQ_SELECT_ASSERT_SVH
`define TIMER16_CTC_WITH_IRQ_SELECT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define T16_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer check failed");

// next-cycle implication, quiet during reset
`define T16_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timer check failed");

`endif

### src/t16_pkg.sv
package t16_pkg;

   // item kinds
   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_IRQ   = 2'd3;

   // byte register selectors
   localparam logic [3:0] REG_CTRL    = 4'd0;
   localparam logic [3:0] REG_CNT_LO  = 4'd1;
   localparam logic [3:0] REG_CNT_HI  = 4'd2;
   localparam logic [3:0] REG_CMPA_LO = 4'd3;
   localparam logic [3:0] REG_CMPA_HI = 4'd4;
   localparam logic [3:0] REG_CMPB_LO = 4'd5;
   localparam logic [3:0] REG_CMPB_HI = 4'd6;
   localparam logic [3:0] REG_FLAGS   = 4'd7;
   localparam logic [3:0] REG_MASK    = 4'd8;

   // control register layout
   localparam int CS_MSB  = 2;
   localparam int CTC_BIT = 3;

   // flag bit positions
   localparam int FLAG_OVF  = 0;
   localparam int FLAG_CMPA = 1;
   localparam int FLAG_CMPB = 2;

   // vectors, word addresses
   localparam logic [14:0] BOOT_BASE = 15'h7800;
   localparam logic [14:0] VEC_COMPA = 15'h001A;
   localparam logic [14:0] VEC_COMPB = 15'h001C;
   localparam logic [14:0] VEC_OVF   = 15'h001E;

   // csr map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_IDX_BOOT = 1'b0;

   typedef struct packed {
      logic [1:0] mode;
      logic [3:0] reg_select;
      logic [7:0] write_data;
      logic       global_enable;
   } t16_req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        irq_taken;
      logic [14:0] irq_vector;
      logic [2:0]  pending_flags;
   } t16_result_type;

endpackage

### src/t16_chan_if.sv
// request channel: one timer operation per beat
interface t16_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [3:0] reg_select;
   logic [7:0] write_data;
   logic       global_enable;

   modport source (output valid, mode, reg_select, write_data, global_enable, input ready);
   modport sink   (input valid, mode, reg_select, write_data, global_enable, output ready);
endinterface

// response channel: one result per beat
interface t16_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        irq_taken;
   logic [14:0] irq_vector;
   logic [2:0]  pending_flags;

   modport source (output valid, read_data, irq_taken, irq_vector, pending_flags, input ready);
   modport sink   (input valid, read_data, irq_taken, irq_vector, pending_flags, output ready);
endinterface

### src/t16_core.sv
`include "timer16_ctc_with_irq_select_assert.svh"

// timer state and the combinational update for one operation
module t16_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  t16_pkg::t16_req_type    req,
   input  logic                    boot_sel,
   output t16_pkg::t16_result_type res
);

   logic [15:0] count_ff, count_in;
   logic [7:0]  latch_ff, latch_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [15:0] cmpa_ff, cmpa_in;
   logic [15:0] cmpb_ff, cmpb_in;
   logic [2:0]  flags_ff, flags_in;
   logic [7:0]  mask_ff, mask_in;

   logic [15:0] count_inc;
   logic        clk_on;
   logic        ctc_on;
   logic [2:0]  pend;
   logic [14:0] base;
   logic [7:0]  rd;
   logic        taken;
   logic [14:0] vec;

   // counter+1 equals cmp+1 exactly when counter equals cmp
   assign count_inc = count_ff + 16'd1;
   assign clk_on    = |ctrl_ff[t16_pkg::CS_MSB:0];
   assign ctc_on    = ctrl_ff[t16_pkg::CTC_BIT];
   assign pend      = flags_ff & mask_ff[2:0];
   assign base      = boot_sel ? t16_pkg::BOOT_BASE : 15'd0;

   // next state and result
   always_comb begin
      count_in = count_ff;
      latch_in = latch_ff;
      ctrl_in  = ctrl_ff;
      cmpa_in  = cmpa_ff;
      cmpb_in  = cmpb_ff;
      flags_in = flags_ff;
      mask_in  = mask_ff;
      rd       = 8'd0;
      taken    = 1'b0;
      vec      = 15'd0;
      unique case (req.mode)
         t16_pkg::MODE_TICK: begin
            count_in = count_inc;
            if (clk_on) begin
               if (count_ff == 16'hFFFF) flags_in[t16_pkg::FLAG_OVF] = 1'b1;
               if (ctc_on) begin
                  if (count_ff == cmpb_ff) flags_in[t16_pkg::FLAG_CMPB] = 1'b1;
                  if (count_ff == cmpa_ff) begin
                     flags_in[t16_pkg::FLAG_CMPA] = 1'b1;
                     count_in = 16'd0;
                  end
               end
            end
         end
         t16_pkg::MODE_WRITE: begin
            unique case (req.reg_select)
               t16_pkg::REG_CTRL:    ctrl_in = req.write_data;
               t16_pkg::REG_CNT_LO:  count_in = {latch_ff, req.write_data};
               t16_pkg::REG_CNT_HI:  latch_in = req.write_data;
               t16_pkg::REG_CMPA_LO: cmpa_in[7:0] = req.write_data;
               t16_pkg::REG_CMPA_HI: cmpa_in[15:8] = req.write_data;
               t16_pkg::REG_CMPB_LO: cmpb_in[7:0] = req.write_data;
               t16_pkg::REG_CMPB_HI: cmpb_in[15:8] = req.write_data;
               t16_pkg::REG_FLAGS:   flags_in = flags_ff & ~req.write_data[2:0];
               t16_pkg::REG_MASK:    mask_in = req.write_data;
               default: ;
            endcase
         end
         t16_pkg::MODE_READ: begin
            unique case (req.reg_select)
               t16_pkg::REG_CTRL: rd = ctrl_ff;
               t16_pkg::REG_CNT_LO: begin
                  rd       = count_ff[7:0];
                  latch_in = count_ff[15:8];
               end
               t16_pkg::REG_CNT_HI:  rd = latch_ff;
               t16_pkg::REG_CMPA_LO: rd = cmpa_ff[7:0];
               t16_pkg::REG_CMPA_HI: rd = cmpa_ff[15:8];
               t16_pkg::REG_CMPB_LO: rd = cmpb_ff[7:0];
               t16_pkg::REG_CMPB_HI: rd = cmpb_ff[15:8];
               t16_pkg::REG_FLAGS:   rd = {5'd0, flags_ff};
               t16_pkg::REG_MASK:    rd = mask_ff;
               default:              rd = 8'd0;
            endcase
         end
         t16_pkg::MODE_IRQ: begin
            // fixed priority: compare a, compare b, overflow
            if (req.global_enable) begin
               if (pend[t16_pkg::FLAG_CMPA]) begin
                  flags_in[t16_pkg::FLAG_CMPA] = 1'b0;
                  taken = 1'b1;
                  vec   = base + t16_pkg::VEC_COMPA;
               end else if (pend[t16_pkg::FLAG_CMPB]) begin
                  flags_in[t16_pkg::FLAG_CMPB] = 1'b0;
                  taken = 1'b1;
                  vec   = base + t16_pkg::VEC_COMPB;
               end else if (pend[t16_pkg::FLAG_OVF]) begin
                  flags_in[t16_pkg::FLAG_OVF] = 1'b0;
                  taken = 1'b1;
                  vec   = base + t16_pkg::VEC_OVF;
               end
            end
         end
         default: ;
      endcase
   end

   assign res.read_data     = rd;
   assign res.irq_taken     = taken;
   assign res.irq_vector    = vec;
   assign res.pending_flags = flags_in;

   // timer state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 16'd0;
         latch_ff <= 8'd0;
         ctrl_ff  <= 8'd0;
         cmpa_ff  <= 16'd0;
         cmpb_ff  <= 16'd0;
         flags_ff <= 3'd0;
         mask_ff  <= 8'd0;
      end else if (step_en) begin
         count_ff <= count_in;
         latch_ff <= latch_in;
         ctrl_ff  <= ctrl_in;
         cmpa_ff  <= cmpa_in;
         cmpb_ff  <= cmpb_in;
         flags_ff <= flags_in;
         mask_ff  <= mask_in;
      end
   end

   // checks
   `T16_ASSERT_SAME(a_no_irq_without_gie, req.mode == t16_pkg::MODE_IRQ && !req.global_enable, !res.irq_taken)
   `T16_ASSERT_SAME(a_vector_only_when_taken, !res.irq_taken, res.irq_vector == 15'd0)
   `T16_ASSERT_NEXT(a_taken_flag_cleared, step_en && res.irq_taken && pend[t16_pkg::FLAG_CMPA], !flags_ff[t16_pkg::FLAG_CMPA])

endmodule

### src/timer16_ctc_with_irq_select.sv
// channel   | dir | beat contents
// ----------+-----+-------------------------------------------------------
// req_if    | in  | mode, reg_select, write_data, global_enable
// rsp_if    | out | read_data, irq_taken, irq_vector, pending_flags
// apb csr   | in  | boot_vector_select at byte address 0
//
// one operation is taken per cycle while req_if is ready; its result is registered
// into the head or the skid entry and shows up on rsp_if once it is at the head
// a two-entry result buffer (head plus skid) keeps req_if ready while one
// result waits; req_if stalls only when both entries are full
// synchronous active-high reset clears all timer state and empties the buffer
`include "timer16_ctc_with_irq_select_assert.svh"

module timer16_ctc_with_irq_select (
   input  logic                                clock,
   input  logic                                reset,
   t16_req_if.sink                             req_if,
   t16_rsp_if.source                           rsp_if,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [t16_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [t16_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [t16_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   logic                    boot_ff;
   logic                    csr_wr;
   logic                    csr_hit;
   logic                    push;
   logic                    pop;
   logic [1:0]              cnt_ff, cnt_in;
   t16_pkg::t16_req_type    req;
   t16_pkg::t16_result_type step_res;
   t16_pkg::t16_result_type head_ff, head_in;
   t16_pkg::t16_result_type skid_ff, skid_in;

   // config port
   assign pready  = 1'b1;
   assign csr_hit = paddr[2] == t16_pkg::REG_IDX_BOOT;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign prdata  = csr_hit ? {{(t16_pkg::CSR_DATA_W-1){1'b0}}, boot_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_ff <= 1'b0;
      end else if (csr_wr && csr_hit) begin
         boot_ff <= pwdata[0];
      end
   end

   // request beat
   assign req.mode          = req_if.mode;
   assign req.reg_select    = req_if.reg_select;
   assign req.write_data    = req_if.write_data;
   assign req.global_enable = req_if.global_enable;

   assign req_if.ready = cnt_ff != 2'd2;
   assign push         = req_if.valid & req_if.ready;
   assign pop          = rsp_if.valid & rsp_if.ready;

   t16_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (push),
      .req      (req),
      .boot_sel (boot_ff),
      .res      (step_res)
   );

   // result buffer: head feeds the port, skid catches one more beat
   always_comb begin
      head_in = head_ff;
      skid_in = skid_ff;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
      if (cnt_ff == 2'd2) begin
         if (pop) head_in = skid_ff;
      end else if (push) begin
         if (cnt_ff == 2'd0 || pop) head_in = step_res;
         else                       skid_in = step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid         = cnt_ff != 2'd0;
   assign rsp_if.read_data     = head_ff.read_data;
   assign rsp_if.irq_taken     = head_ff.irq_taken;
   assign rsp_if.irq_vector    = head_ff.irq_vector;
   assign rsp_if.pending_flags = head_ff.pending_flags;

   // checks
   `T16_ASSERT_SAME(a_buf_bounded, 1'b1, cnt_ff != 2'd3)
   `T16_ASSERT_NEXT(a_buf_fill, push && !pop, cnt_ff == $past(cnt_ff) + 2'd1)
   `T16_ASSERT_NEXT(a_buf_drain, pop && !push, cnt_ff == $past(cnt_ff) - 2'd1)

endmodule

### tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADDR_W = t16_pkg::CSR_ADDR_W;
   localparam int DATA_W = t16_pkg::CSR_DATA_W;
   localparam logic [3:0] REG_UNUSED_LO = 4'd9;
   localparam logic [3:0] REG_UNUSED_HI = 4'd15;
   localparam logic [ADDR_W-1:0] BOOT_ADDR = ADDR_W'(4 * t16_pkg::REG_IDX_BOOT);
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic pready;

   t16_req_if req_bus ();
   t16_rsp_if rsp_bus ();

   timer16_ctc_with_irq_select DUT (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predicted timer state
   logic [15:0] count;
   logic [7:0]  hi_latch;
   logic [7:0]  ctrl_reg;
   logic [15:0] cmp_a;
   logic [15:0] cmp_b;
   logic [2:0]  flags;
   logic [7:0]  mask_reg;
   logic        boot_select;

   t16_pkg::t16_result_type expected_results[$];
   int mismatch_count = 0;
   int beat_index = 0;
   bit idle_on = 1'b1;
   int hold_request = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // timer behavior for one operation, updates the predicted state
   function automatic t16_pkg::t16_result_type timer_step(t16_pkg::t16_req_type op);
      t16_pkg::t16_result_type res;
      logic [15:0] hit_a;
      logic [15:0] hit_b;
      logic [2:0] pend;
      logic [14:0] base;
      res = '0;
      base = boot_select ? t16_pkg::BOOT_BASE : 15'd0;
      case (op.mode)
         t16_pkg::MODE_TICK: begin
            hit_a = cmp_a + 16'd1;
            hit_b = cmp_b + 16'd1;
            count = count + 16'd1;
            if (ctrl_reg[t16_pkg::CS_MSB:0] != '0) begin
               if (count == 16'd0) flags[t16_pkg::FLAG_OVF] = 1'b1;
               if (ctrl_reg[t16_pkg::CTC_BIT]) begin
                  if (count == hit_b) flags[t16_pkg::FLAG_CMPB] = 1'b1;
                  if (count == hit_a) begin
                     flags[t16_pkg::FLAG_CMPA] = 1'b1;
                     count = 16'd0;
                  end
               end
            end
         end
         t16_pkg::MODE_WRITE: begin
            case (op.reg_select)
               t16_pkg::REG_CTRL:    ctrl_reg = op.write_data;
               t16_pkg::REG_CNT_LO:  count = {hi_latch, op.write_data};
               t16_pkg::REG_CNT_HI:  hi_latch = op.write_data;
               t16_pkg::REG_CMPA_LO: cmp_a[7:0] = op.write_data;
               t16_pkg::REG_CMPA_HI: cmp_a[15:8] = op.write_data;
               t16_pkg::REG_CMPB_LO: cmp_b[7:0] = op.write_data;
               t16_pkg::REG_CMPB_HI: cmp_b[15:8] = op.write_data;
               t16_pkg::REG_FLAGS:   flags = flags & ~op.write_data[2:0];
               t16_pkg::REG_MASK:    mask_reg = op.write_data;
               default: ;
            endcase
         end
         t16_pkg::MODE_READ: begin
            case (op.reg_select)
               t16_pkg::REG_CTRL:    res.read_data = ctrl_reg;
               t16_pkg::REG_CNT_LO: begin
                  hi_latch = count[15:8];
                  res.read_data = count[7:0];
               end
               t16_pkg::REG_CNT_HI:  res.read_data = hi_latch;
               t16_pkg::REG_CMPA_LO: res.read_data = cmp_a[7:0];
               t16_pkg::REG_CMPA_HI: res.read_data = cmp_a[15:8];
               t16_pkg::REG_CMPB_LO: res.read_data = cmp_b[7:0];
               t16_pkg::REG_CMPB_HI: res.read_data = cmp_b[15:8];
               t16_pkg::REG_FLAGS:   res.read_data = {5'd0, flags};
               t16_pkg::REG_MASK:    res.read_data = mask_reg;
               default:              res.read_data = 8'd0;
            endcase
         end
         default: begin
            // interrupt check: compare a, then compare b, then overflow
            if (op.global_enable) begin
               pend = flags & mask_reg[2:0];
               if (pend[t16_pkg::FLAG_CMPA]) begin
                  flags[t16_pkg::FLAG_CMPA] = 1'b0;
                  res.irq_taken = 1'b1;
                  res.irq_vector = base + t16_pkg::VEC_COMPA;
               end else if (pend[t16_pkg::FLAG_CMPB]) begin
                  flags[t16_pkg::FLAG_CMPB] = 1'b0;
                  res.irq_taken = 1'b1;
                  res.irq_vector = base + t16_pkg::VEC_COMPB;
               end else if (pend[t16_pkg::FLAG_OVF]) begin
                  flags[t16_pkg::FLAG_OVF] = 1'b0;
                  res.irq_taken = 1'b1;
                  res.irq_vector = base + t16_pkg::VEC_OVF;
               end
            end
         end
      endcase
      res.pending_flags = flags;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("[%0t] beat %0d: %s got 0x%0h expected 0x%0h", $realtime, beat_index, what,
               got, want);
   endtask

   // result checking and prediction on accepted beats
   always @(posedge clock) begin : check_results
      t16_pkg::t16_req_type seen;
      t16_pkg::t16_result_type want;
      if (reset) begin
         count = '0;
         hi_latch = '0;
         ctrl_reg = '0;
         cmp_a = '0;
         cmp_b = '0;
         flags = '0;
         mask_reg = '0;
         boot_select = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_bus.pending_flags, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_bus.read_data !== want.read_data)
                  report_mismatch("read_data", rsp_bus.read_data, want.read_data);
               if (rsp_bus.irq_taken !== want.irq_taken)
                  report_mismatch("irq_taken", rsp_bus.irq_taken, want.irq_taken);
               if (rsp_bus.irq_vector !== want.irq_vector)
                  report_mismatch("irq_vector", rsp_bus.irq_vector, want.irq_vector);
               if (rsp_bus.pending_flags !== want.pending_flags)
                  report_mismatch("pending_flags", rsp_bus.pending_flags, want.pending_flags);
            end
            beat_index++;
         end
         if (req_bus.valid && req_bus.ready) begin
            seen.mode = req_bus.mode;
            seen.reg_select = req_bus.reg_select;
            seen.write_data = req_bus.write_data;
            seen.global_enable = req_bus.global_enable;
            expected_results.push_back(timer_step(seen));
         end
      end
   end

   // result side ready, random stalls plus requested long hold-off
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else if (idle_on) begin
         rsp_bus.ready <= ($urandom_range(99) >= 16);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timer16_ctc_with_irq_select test failed");
         $finish;
      end
   end

   // offer one operation and wait for its beat
   task automatic send_op(input logic [1:0] mode, input logic [3:0] sel,
                          input logic [7:0] data, input logic gie);
      if (idle_on && $urandom_range(99) < 16) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= mode;
      req_bus.reg_select <= sel;
      req_bus.write_data <= data;
      req_bus.global_enable <= gie;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // apb write: setup then access phase
   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // boot vector select, only written with the timer idle
   task automatic set_boot_select(input logic value);
      wait_for_drain();
      repeat (2) @(posedge clock);
      csr_write(BOOT_ADDR, {31'd0, value});
      boot_select = value;
   endtask

   // one random operation, biased so compares and overflows actually fire
   task automatic send_random_op();
      logic [1:0] mode;
      logic [3:0] sel;
      logic [7:0] data;
      logic gie;
      int pick;
      pick = $urandom_range(99);
      sel = 4'($urandom_range(8));
      if ($urandom_range(15) == 0) sel = 4'($urandom_range(15));
      data = 8'($urandom);
      gie = ($urandom_range(9) != 0);
      if (pick < 45) begin
         mode = t16_pkg::MODE_TICK;
      end else if (pick < 62) begin
         mode = t16_pkg::MODE_WRITE;
         case (sel) inside
            t16_pkg::REG_CMPA_HI, t16_pkg::REG_CMPB_HI:
               if ($urandom_range(3) != 0) data = 8'h00;
            t16_pkg::REG_CMPA_LO, t16_pkg::REG_CMPB_LO:
               if ($urandom_range(3) != 0) data = 8'($urandom_range(12));
            t16_pkg::REG_CNT_HI: if ($urandom_range(1) != 0) data = 8'hFF;
            default: ;
         endcase
      end else if (pick < 75) begin
         mode = t16_pkg::MODE_READ;
      end else begin
         mode = t16_pkg::MODE_IRQ;
      end
      send_op(mode, sel, data, gie);
   endtask

   // mostly well-formed count accesses and single random operations
   task automatic run_random_ops(input int n);
      int sent;
      int r;
      sent = 0;
      while (sent < n) begin
         r = $urandom_range(9);
         if (r == 0) begin
            send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_CNT_HI, 8'($urandom), 1'b0);
            send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_CNT_LO, 8'($urandom), 1'b0);
            sent += 2;
         end else if (r == 1) begin
            send_op(t16_pkg::MODE_READ, t16_pkg::REG_CNT_LO, 8'h00, 1'b0);
            send_op(t16_pkg::MODE_READ, t16_pkg::REG_CNT_HI, 8'h00, 1'b0);
            sent += 2;
         end else begin
            send_random_op();
            sent++;
         end
      end
   endtask

   // register extremes, unused selectors and the count latch
   task automatic test_register_access();
      send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_CTRL, 8'hFF, 1'b0);
      send_op(t16_pkg::MODE_READ, t16_pkg::REG_CTRL, 8'h00, 1'b0);
      send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_CMPA_LO, 8'hFF, 1'b0);
      send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_CMPA_HI, 8'hFF, 1'b0);
      send_op(t16_pkg::MODE_READ, t16_pkg::REG_CMPA_LO, 8'h00, 1'b0);
      send_op(t16_pkg::MODE_READ, t16_pkg::REG_CMPA_HI, 8'h00, 1'b0);
      send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_CMPB_LO, 8'h00, 1'b1);
      send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_CMPB_HI, 8'h00, 1'b1);
      send_op(t16_pkg::MODE_READ, t16_pkg::REG_CMPB_HI, 8'h00, 1'b0);
      send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_MASK, 8'hFF, 1'b0);
      send_op(t16_pkg::MODE_READ, t16_pkg::REG_MASK, 8'h00, 1'b0);
      send_op(t16_pkg::MODE_WRITE, REG_UNUSED_LO, 8'hFF, 1'b0);
      send_op(t16_pkg::MODE_READ, REG_UNUSED_HI, 8'hFF, 1'b1);
      send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_CNT_HI, 8'hFF, 1'b0);
      send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_CNT_LO, 8'hFE, 1'b0);
      send_op(t16_pkg::MODE_READ, t16_pkg::REG_CNT_LO, 8'h00, 1'b0);
      send_op(t16_pkg::MODE_READ, t16_pkg::REG_CNT_HI, 8'h00, 1'b0);
   endtask

   // compare a at its top value, compare b, interrupt priority and flag clears
   task automatic test_compare_and_irq();
      send_op(t16_pkg::MODE_TICK, t16_pkg::REG_CTRL, 8'h00, 1'b0);
      send_op(t16_pkg::MODE_TICK, t16_pkg::REG_CTRL, 8'h00, 1'b0);
      send_op(t16_pkg::MODE_TICK, t16_pkg::REG_CTRL, 8'h00, 1'b0);
      send_op(t16_pkg::MODE_IRQ, t16_pkg::REG_CTRL, 8'h00, 1'b0);
      send_op(t16_pkg::MODE_IRQ, t16_pkg::REG_CTRL, 8'h00, 1'b1);
      send_op(t16_pkg::MODE_IRQ, t16_pkg::REG_CTRL, 8'h00, 1'b1);
      send_op(t16_pkg::MODE_IRQ, t16_pkg::REG_CTRL, 8'h00, 1'b1);
      send_op(t16_pkg::MODE_IRQ, t16_pkg::REG_CTRL, 8'h00, 1'b1);
      // stopped clock: count moves, no flags
      send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_CTRL, 8'h08, 1'b0);
      send_op(t16_pkg::MODE_TICK, t16_pkg::REG_CTRL, 8'h00, 1'b0);
      // normal mode overflow, then flag clears
      send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_CTRL, 8'h01, 1'b0);
      send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_CNT_HI, 8'hFF, 1'b0);
      send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_CNT_LO, 8'hFF, 1'b0);
      send_op(t16_pkg::MODE_TICK, t16_pkg::REG_CTRL, 8'h00, 1'b0);
      send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_FLAGS, 8'hFE, 1'b0);
      send_op(t16_pkg::MODE_WRITE, t16_pkg::REG_FLAGS, 8'h01, 1'b0);
      send_op(t16_pkg::MODE_READ, t16_pkg::REG_FLAGS, 8'h00, 1'b0);
   endtask

   // no idling on either side
   task automatic test_back_to_back(input int n);
      idle_on = 1'b0;
      run_random_ops(n);
      idle_on = 1'b1;
   endtask

   // long result hold-off while operations keep coming
   task automatic test_result_backpressure(input int n);
      hold_request = HOLD_CYCLES;
      run_random_ops(n);
   endtask

   // bursts separated by a full drain
   task automatic test_drain_pause(input int bursts, input int n);
      repeat (bursts) begin
         run_random_ops(n);
         wait_for_drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.mode = t16_pkg::MODE_TICK;
      req_bus.reg_select = t16_pkg::REG_CTRL;
      req_bus.write_data = 8'h00;
      req_bus.global_enable = 1'b0;
      rsp_bus.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      set_boot_select(1'b0);
      test_register_access();
      test_compare_and_irq();
      set_boot_select(1'b1);
      run_random_ops(600);
      test_back_to_back(400);
      test_result_backpressure(80);
      set_boot_select(1'b0);
      run_random_ops(400);
      test_drain_pause(3, 50);

      wait_for_drain();
      repeat (4) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never arrived", 0, expected_results.size());
      if (mismatch_count == 0) begin
         $display("timer16_ctc_with_irq_select test passed");
      end else begin
         $display("timer16_ctc_with_irq_select test failed");
      end
      $finish;
   end

endmodule
